// ===== rtl/cbm_pkg.sv =====
package cbm_pkg;

  localparam int FUNC_W    = 3;
  localparam int BYTES_W   = 15;
  localparam int CELL_W    = 12;
  localparam int STAT_W    = 2;
  localparam int CNT_W     = 13;
  localparam int CODE_W    = 4;
  localparam int HDR_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int REQ_W     = 12;

  localparam logic [FUNC_W-1:0] FN_PAIR   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_OBJ    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_MARK   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SWEEP  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REWIND = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_MARKED = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTOBJ = 2'd3;

  localparam logic [1:0] TY_FREE = 2'd0;
  localparam logic [1:0] TY_PAIR = 2'd1;
  localparam logic [1:0] TY_HEAD = 2'd2;
  localparam logic [1:0] TY_BODY = 2'd3;

  localparam logic [1:0] CO_WHITE  = 2'd0;
  localparam logic [1:0] CO_GREY   = 2'd1;
  localparam logic [1:0] CO_BLACK  = 2'd2;
  localparam logic [1:0] CO_XBLACK = 2'd3;

  localparam logic [CODE_W-1:0] CODE_FREE = {CO_WHITE, TY_FREE};
  localparam logic [CODE_W-1:0] CODE_HDR  = {CO_WHITE, TY_BODY};

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PINNED = 2'd1;

  localparam int MAX_BYTES = 16384;

endpackage

// ===== rtl/cbm_ram.sv =====
module cbm_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [cbm_pkg::CODE_W-1:0]    wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [cbm_pkg::CODE_W-1:0]    rdata
);

  logic [cbm_pkg::CODE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/cell_bitmap_alloc_mark_sweep.sv =====
// Cell map allocator with mark and sweep for one chunk of CHUNK_CELLS cells.
// Input channel (in_valid/in_ready) takes one request: allocate pair,
// allocate object, mark, sweep or rewind. Result channel (out_valid/out_ready)
// gives exactly one item per request, always carrying the last sweep counts.
// The cell codes sit in one synchronous RAM; scans issue one read per cycle
// and write back the cell behind the read pointer.
// Rewind and rejected requests go straight to the result. Allocation scans
// from the rover toward the end of the chunk, one cell per read, and an
// object then writes its head and body cells one by one. Sweep reads every
// cell. Mark reads its cell; for an object it then colors each body cell,
// and a conservative walk back reads each body cell toward the head first.
// The RAM port, one cell per cycle, paces these steps. Reset, and every
// write of header_cells, starts a clearing pass over all CHUNK_CELLS cells
// that presets the map; no item is taken meanwhile.
// The configuration port is always ready.
// A finished result waits in the output register while out_ready is low;
// the next request is already accepted, and its result holds until the
// output register frees.
module cell_bitmap_alloc_mark_sweep #(
  parameter int CHUNK_CELLS = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [cbm_pkg::FUNC_W-1:0]       in_func,
  input  logic [cbm_pkg::BYTES_W-1:0]      in_alloc_bytes,
  input  logic [cbm_pkg::CELL_W-1:0]       in_cell_index,
  input  logic                             in_conservative,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cbm_pkg::STAT_W-1:0]       out_status,
  output logic [cbm_pkg::CELL_W-1:0]       out_found_cell,
  output logic [1:0]                       out_found_type,
  output logic [cbm_pkg::CNT_W-1:0]        out_used_cells,
  output logic [cbm_pkg::CNT_W-1:0]        out_free_cells,
  output logic [cbm_pkg::CNT_W-1:0]        out_freed_cells,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbm_pkg::HDR_W-1:0]        cfg_wdata
);

  localparam int AW = $clog2(CHUNK_CELLS);
  localparam logic [AW:0]   CHUNK_W = (AW+1)'(CHUNK_CELLS);
  localparam logic [AW-1:0] LAST_A  = AW'(CHUNK_CELLS - 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_PAIR = 4'd2;
  localparam logic [3:0] S_OBJ  = 4'd3;
  localparam logic [3:0] S_OBJW = 4'd4;
  localparam logic [3:0] S_MKRD = 4'd5;
  localparam logic [3:0] S_MKEV = 4'd6;
  localparam logic [3:0] S_BODY = 4'd7;
  localparam logic [3:0] S_SWP  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]      state_r, state_nxt;
  logic [AW:0]     rd_addr_r, rd_addr_nxt;
  logic            dv_r, dv_nxt;
  logic [AW-1:0]   da_r, da_nxt;
  logic [AW:0]     rover_r, rover_nxt;
  logic [cbm_pkg::HDR_W-1:0] hdr_r, hdr_nxt;
  logic            pinned_r, pinned_nxt;
  logic [AW:0]     used_r, used_nxt, free_r, free_nxt, freed_r, freed_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [AW-1:0]   m_r, m_nxt;
  logic            cons_r, cons_nxt;
  logic [1:0]      col_r, col_nxt;
  logic [cbm_pkg::REQ_W-1:0] req_r, req_nxt, run_len_r, run_len_nxt;
  logic [AW-1:0]   run_start_r, run_start_nxt, w_r, w_nxt, wend_r, wend_nxt;
  logic            skip_r, skip_nxt;
  logic [cbm_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [cbm_pkg::CELL_W-1:0] res_cell_r, res_cell_nxt;
  logic [1:0]      res_type_r, res_type_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [cbm_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [cbm_pkg::CELL_W-1:0] out_cell_r, out_cell_nxt;
  logic [1:0]      out_type_r, out_type_nxt;
  logic [cbm_pkg::CNT_W-1:0] out_used_r, out_used_nxt, out_free_r, out_free_nxt;
  logic [cbm_pkg::CNT_W-1:0] out_freed_r, out_freed_nxt;

  logic                       we, re, issue;
  logic [AW-1:0]              waddr, raddr;
  logic [cbm_pkg::CODE_W-1:0] wdata, rd_data;
  logic                       scan_end, can_issue, found;
  logic [AW-1:0]              start_sel;
  logic [cbm_pkg::REQ_W-1:0]  req_w;
  logic [1:0]                 c_ty, c_co;

  cbm_ram #(.DEPTH(CHUNK_CELLS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign c_ty      = rd_data[1:0];
  assign c_co      = rd_data[3:2];
  assign scan_end  = !dv_r && (rd_addr_r == CHUNK_W);
  assign can_issue = (rd_addr_r != CHUNK_W);
  assign start_sel = (run_len_r == '0) ? da_r : run_start_r;
  assign raddr     = (state_r == S_MKRD) ? m_r : rd_addr_r[AW-1:0];
  assign re        = issue || (state_r == S_MKRD);

  always_comb begin
    req_w = cbm_pkg::REQ_W'((16'(in_alloc_bytes) + 16'd7) >> 3);
    if (req_w == '0) begin
      req_w = cbm_pkg::REQ_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;      rd_addr_nxt = rd_addr_r;  da_nxt = rd_addr_r[AW-1:0];
    rover_nxt = rover_r;      hdr_nxt = hdr_r;          pinned_nxt = pinned_r;
    used_nxt = used_r;        free_nxt = free_r;        freed_nxt = freed_r;
    clr_nxt = clr_r;          m_nxt = m_r;              cons_nxt = cons_r;
    col_nxt = col_r;          req_nxt = req_r;          run_len_nxt = run_len_r;
    run_start_nxt = run_start_r; w_nxt = w_r;           wend_nxt = wend_r;
    skip_nxt = skip_r;        res_status_nxt = res_status_r;
    res_cell_nxt = res_cell_r; res_type_nxt = res_type_r;
    out_valid_nxt = out_valid_r; out_status_nxt = out_status_r;
    out_cell_nxt = out_cell_r; out_type_nxt = out_type_r;
    out_used_nxt = out_used_r; out_free_nxt = out_free_r; out_freed_nxt = out_freed_r;
    we = 1'b0; waddr = da_r; wdata = cbm_pkg::CODE_FREE;
    issue = 1'b0; found = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        we = 1'b1;
        waddr = clr_r;
        wdata = (32'(clr_r) < 32'(hdr_r)) ? cbm_pkg::CODE_HDR : cbm_pkg::CODE_FREE;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_A) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_status_nxt = cbm_pkg::ST_DONE;
          res_cell_nxt = '0;
          res_type_nxt = cbm_pkg::TY_FREE;
          case (in_func)
            cbm_pkg::FN_PAIR: begin
              res_status_nxt = cbm_pkg::ST_FULL;
              rd_addr_nxt = rover_r;
              state_nxt = pinned_r ? S_OUT : S_PAIR;
            end
            cbm_pkg::FN_OBJ: begin
              res_status_nxt = cbm_pkg::ST_FULL;
              rd_addr_nxt = rover_r;
              req_nxt = req_w;
              run_len_nxt = '0;
              if (pinned_r || (32'(in_alloc_bytes) > cbm_pkg::MAX_BYTES)) begin
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_OBJ;
              end
            end
            cbm_pkg::FN_MARK: begin
              m_nxt = AW'(in_cell_index);
              cons_nxt = in_conservative;
              if (32'(in_cell_index) >= CHUNK_CELLS) begin
                res_status_nxt = cbm_pkg::ST_NOTOBJ;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_MKRD;
              end
            end
            cbm_pkg::FN_SWEEP: begin
              used_nxt = '0;
              free_nxt = '0;
              freed_nxt = '0;
              skip_nxt = 1'b1;
              rd_addr_nxt = '0;
              state_nxt = S_SWP;
            end
            cbm_pkg::FN_REWIND: begin
              rover_nxt = '0;
              state_nxt = S_OUT;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_PAIR: begin
        if (dv_r && rd_data == cbm_pkg::CODE_FREE) begin
          we = 1'b1;
          wdata = {cbm_pkg::CO_GREY, cbm_pkg::TY_PAIR};
          rover_nxt = (AW+1)'(da_r) + 1'b1;
          res_status_nxt = cbm_pkg::ST_DONE;
          res_cell_nxt = cbm_pkg::CELL_W'(da_r);
          res_type_nxt = cbm_pkg::TY_PAIR;
          state_nxt = S_OUT;
        end else if (scan_end) begin
          state_nxt = S_OUT;
        end else begin
          issue = can_issue;
        end
      end
      S_OBJ: begin
        if (dv_r) begin
          if (rd_data == cbm_pkg::CODE_FREE) begin
            run_start_nxt = start_sel;
            run_len_nxt = run_len_r + 1'b1;
            if (run_len_r + 1'b1 == req_r) begin
              found = 1'b1;
              w_nxt = start_sel;
              wend_nxt = AW'(32'(start_sel) + 32'(req_r) - 1);
              rover_nxt = (AW+1)'(32'(start_sel) + 32'(req_r));
              res_status_nxt = cbm_pkg::ST_DONE;
              res_cell_nxt = cbm_pkg::CELL_W'(start_sel);
              res_type_nxt = cbm_pkg::TY_HEAD;
              state_nxt = S_OBJW;
            end
          end else begin
            run_len_nxt = '0;
          end
        end
        if (!found) begin
          if (scan_end) begin
            state_nxt = S_OUT;
          end else begin
            issue = can_issue;
          end
        end
      end
      S_OBJW: begin
        we = 1'b1;
        waddr = w_r;
        wdata = (w_r == run_start_r) ? {cbm_pkg::CO_GREY, cbm_pkg::TY_HEAD}
                                     : {cbm_pkg::CO_GREY, cbm_pkg::TY_BODY};
        w_nxt = w_r + 1'b1;
        if (w_r == wend_r) begin
          state_nxt = S_OUT;
        end
      end
      S_MKRD: begin
        state_nxt = S_MKEV;
      end
      S_MKEV: begin
        res_cell_nxt = cbm_pkg::CELL_W'(m_r);
        res_type_nxt = c_ty;
        if (cons_r && c_ty == cbm_pkg::TY_BODY && m_r != '0) begin
          // conservative reference into a body: step back toward the head
          m_nxt = m_r - 1'b1;
          state_nxt = S_MKRD;
        end else if (c_ty == cbm_pkg::TY_FREE || c_ty == cbm_pkg::TY_BODY) begin
          res_status_nxt = cbm_pkg::ST_NOTOBJ;
          res_cell_nxt = '0;
          res_type_nxt = cbm_pkg::TY_FREE;
          state_nxt = S_OUT;
        end else if (c_co == cbm_pkg::CO_BLACK ||
                     (cons_r && c_co == cbm_pkg::CO_XBLACK)) begin
          res_status_nxt = cbm_pkg::ST_MARKED;
          state_nxt = S_OUT;
        end else begin
          col_nxt = cons_r ? cbm_pkg::CO_XBLACK : cbm_pkg::CO_BLACK;
          we = 1'b1;
          waddr = m_r;
          wdata = {col_nxt, c_ty};
          res_status_nxt = cbm_pkg::ST_DONE;
          rd_addr_nxt = (AW+1)'(m_r) + 1'b1;
          state_nxt = (c_ty == cbm_pkg::TY_PAIR) ? S_OUT : S_BODY;
        end
      end
      S_BODY: begin
        if (dv_r && c_ty != cbm_pkg::TY_BODY) begin
          state_nxt = S_OUT;
        end else begin
          if (dv_r) begin
            we = 1'b1;
            wdata = {col_r, cbm_pkg::TY_BODY};
          end
          if (scan_end) begin
            state_nxt = S_OUT;
          end else begin
            issue = can_issue;
          end
        end
      end
      S_SWP: begin
        if (dv_r && !(skip_r && rd_data == cbm_pkg::CODE_HDR)) begin
          skip_nxt = 1'b0;
          if (c_co == cbm_pkg::CO_WHITE && !pinned_r) begin
            if (rd_data != cbm_pkg::CODE_FREE) begin
              we = 1'b1;
              wdata = cbm_pkg::CODE_FREE;
              freed_nxt = freed_r + 1'b1;
            end else begin
              free_nxt = free_r + 1'b1;
            end
          end else begin
            used_nxt = used_r + 1'b1;
          end
          if (c_co == cbm_pkg::CO_GREY || c_co == cbm_pkg::CO_BLACK) begin
            we = 1'b1;
            wdata = {cbm_pkg::CO_WHITE, c_ty};
          end
        end
        if (scan_end) begin
          state_nxt = S_OUT;
        end else begin
          issue = can_issue;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = res_status_r;
          out_cell_nxt = res_cell_r;
          out_type_nxt = res_type_r;
          out_used_nxt = cbm_pkg::CNT_W'(used_r);
          out_free_nxt = cbm_pkg::CNT_W'(free_r);
          out_freed_nxt = cbm_pkg::CNT_W'(freed_r);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    dv_nxt = issue;
    if (issue) begin
      rd_addr_nxt = rd_addr_r + 1'b1;
    end

    if (cfg_valid) begin
      case (cfg_index)
        cbm_pkg::CFG_HEADER: begin
          hdr_nxt = cfg_wdata;
          clr_nxt = '0;
          rover_nxt = '0;
          used_nxt = '0;
          free_nxt = '0;
          freed_nxt = '0;
          state_nxt = S_CLR;
        end
        cbm_pkg::CFG_PINNED: begin
          pinned_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      hdr_r       <= cbm_pkg::HDR_W'(4);
      pinned_r    <= 1'b0;
      rover_r     <= '0;
      used_r      <= '0;
      free_r      <= '0;
      freed_r     <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      hdr_r       <= hdr_nxt;
      pinned_r    <= pinned_nxt;
      rover_r     <= rover_nxt;
      used_r      <= used_nxt;
      free_r      <= free_nxt;
      freed_r     <= freed_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r    <= rd_addr_nxt;
    da_r         <= da_nxt;
    m_r          <= m_nxt;
    cons_r       <= cons_nxt;
    col_r        <= col_nxt;
    req_r        <= req_nxt;
    run_len_r    <= run_len_nxt;
    run_start_r  <= run_start_nxt;
    w_r          <= w_nxt;
    wend_r       <= wend_nxt;
    skip_r       <= skip_nxt;
    res_status_r <= res_status_nxt;
    res_cell_r   <= res_cell_nxt;
    res_type_r   <= res_type_nxt;
    out_status_r <= out_status_nxt;
    out_cell_r   <= out_cell_nxt;
    out_type_r   <= out_type_nxt;
    out_used_r   <= out_used_nxt;
    out_free_r   <= out_free_nxt;
    out_freed_r  <= out_freed_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_cell  = out_cell_r;
  assign out_found_type  = out_type_r;
  assign out_used_cells  = out_used_r;
  assign out_free_cells  = out_free_r;
  assign out_freed_cells = out_freed_r;

endmodule

// ===== tb/cell_bitmap_alloc_mark_sweep_test.sv =====
`timescale 1ns / 1ps

module cell_bitmap_alloc_mark_sweep_test;

  localparam int CELLS = 4096;
  localparam logic [cbm_pkg::FUNC_W-1:0] FN_UNK_LO = 3'd5;
  localparam logic [cbm_pkg::FUNC_W-1:0] FN_UNK_HI = 3'd7;
  localparam logic [cbm_pkg::CFG_IDX_W-1:0] CFG_NONE_LO = 2'd2;
  localparam logic [cbm_pkg::CFG_IDX_W-1:0] CFG_NONE_HI = 2'd3;

  typedef struct packed {
    logic [cbm_pkg::STAT_W-1:0] status;
    logic [cbm_pkg::CELL_W-1:0] fcell;
    logic [1:0]                 ctype;
    logic [cbm_pkg::CNT_W-1:0]  used;
    logic [cbm_pkg::CNT_W-1:0]  free;
    logic [cbm_pkg::CNT_W-1:0]  freed;
  } alloc_result_t;

  typedef struct {
    logic [cbm_pkg::FUNC_W-1:0]  func;
    logic [cbm_pkg::BYTES_W-1:0] bytes;
    logic [cbm_pkg::CELL_W-1:0]  idx;
    logic                        cons;
    bit                          typed;
    logic [cbm_pkg::STAT_W-1:0]  status;
    logic [cbm_pkg::CELL_W-1:0]  fcell;
    logic [1:0]                  ctype;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [cbm_pkg::FUNC_W-1:0] in_func;
  logic [cbm_pkg::BYTES_W-1:0] in_alloc_bytes;
  logic [cbm_pkg::CELL_W-1:0] in_cell_index;
  logic in_conservative;
  logic out_valid, out_ready;
  logic [cbm_pkg::STAT_W-1:0] out_status;
  logic [cbm_pkg::CELL_W-1:0] out_found_cell;
  logic [1:0] out_found_type;
  logic [cbm_pkg::CNT_W-1:0] out_used_cells, out_free_cells, out_freed_cells;
  logic cfg_valid, cfg_ready;
  logic [cbm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cbm_pkg::HDR_W-1:0] cfg_wdata;

  cell_bitmap_alloc_mark_sweep DUT (.*);

  // mirror of the chunk
  logic [cbm_pkg::CODE_W-1:0] map_codes [CELLS];
  int unsigned roving, hdr_cells, used_n, free_n, freed_n;
  bit chunk_pinned;

  alloc_result_t pending_results[$];
  int errors;
  bit no_idle;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Mismatches found");
    $finish;
  end

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic preset_chunk();
    for (int k = 0; k < CELLS; k++)
      map_codes[k] = (k < hdr_cells) ? cbm_pkg::CODE_HDR : cbm_pkg::CODE_FREE;
    roving = 0;
    used_n = 0;
    free_n = 0;
    freed_n = 0;
  endtask

  function automatic logic [cbm_pkg::CODE_W-1:0] code_of(logic [1:0] co, logic [1:0] ty);
    return {co, ty};
  endfunction

  task automatic predict_alloc(input logic [cbm_pkg::FUNC_W-1:0] func,
                               input logic [cbm_pkg::BYTES_W-1:0] bytes,
                               input logic [cbm_pkg::CELL_W-1:0] cidx, input logic cons,
                               output alloc_result_t r);
    int i, j, req, idx;
    logic [cbm_pkg::CODE_W-1:0] c;
    logic [1:0] col;
    r = '0;
    idx = int'(cidx);
    case (func)
      cbm_pkg::FN_PAIR: begin
        r.status = cbm_pkg::ST_FULL;
        if (!chunk_pinned) begin
          for (i = roving; i < CELLS; i++) begin
            if (map_codes[i] == cbm_pkg::CODE_FREE) begin
              map_codes[i] = code_of(cbm_pkg::CO_GREY, cbm_pkg::TY_PAIR);
              roving = i + 1;
              r.status = cbm_pkg::ST_DONE;
              r.fcell = cbm_pkg::CELL_W'(i);
              r.ctype = cbm_pkg::TY_PAIR;
              break;
            end
          end
        end
      end
      cbm_pkg::FN_OBJ: begin
        r.status = cbm_pkg::ST_FULL;
        if (!chunk_pinned && bytes <= cbm_pkg::MAX_BYTES) begin
          req = (bytes + 7) >> 3;
          if (req == 0) req = 1;
          i = roving;
          while (i < CELLS) begin
            if (map_codes[i] == cbm_pkg::CODE_FREE) begin
              j = 0;
              while (j < req && i + j < CELLS && map_codes[i + j] == cbm_pkg::CODE_FREE) j++;
              if (j == req) begin
                map_codes[i] = code_of(cbm_pkg::CO_GREY, cbm_pkg::TY_HEAD);
                for (j = 1; j < req; j++)
                  map_codes[i + j] = code_of(cbm_pkg::CO_GREY, cbm_pkg::TY_BODY);
                roving = i + req;
                r.status = cbm_pkg::ST_DONE;
                r.fcell = cbm_pkg::CELL_W'(i);
                r.ctype = cbm_pkg::TY_HEAD;
                break;
              end
              i += j;
            end
            i++;
          end
        end
      end
      cbm_pkg::FN_MARK: begin
        if (cons)
          while (idx > 0 && map_codes[idx][1:0] == cbm_pkg::TY_BODY) idx--;
        c = map_codes[idx];
        if (c[1:0] == cbm_pkg::TY_FREE || c[1:0] == cbm_pkg::TY_BODY) begin
          r.status = cbm_pkg::ST_NOTOBJ;
        end else if (c[3:2] == cbm_pkg::CO_BLACK ||
                     (cons && c[3:2] == cbm_pkg::CO_XBLACK)) begin
          r.status = cbm_pkg::ST_MARKED;
          r.fcell = cbm_pkg::CELL_W'(idx);
          r.ctype = c[1:0];
        end else begin
          col = cons ? cbm_pkg::CO_XBLACK : cbm_pkg::CO_BLACK;
          map_codes[idx] = code_of(col, c[1:0]);
          if (c[1:0] == cbm_pkg::TY_HEAD)
            for (j = idx + 1; j < CELLS && map_codes[j][1:0] == cbm_pkg::TY_BODY; j++)
              map_codes[j] = code_of(col, cbm_pkg::TY_BODY);
          r.fcell = cbm_pkg::CELL_W'(idx);
          r.ctype = c[1:0];
        end
      end
      cbm_pkg::FN_SWEEP: begin
        used_n = 0;
        free_n = 0;
        freed_n = 0;
        for (i = 0; i < CELLS && map_codes[i] == cbm_pkg::CODE_HDR; i++) begin
        end
        for (; i < CELLS; i++) begin
          c = map_codes[i];
          if (c[3:2] == cbm_pkg::CO_WHITE && !chunk_pinned) begin
            if (c != cbm_pkg::CODE_FREE) begin
              map_codes[i] = cbm_pkg::CODE_FREE;
              freed_n++;
            end else begin
              free_n++;
            end
          end else begin
            used_n++;
          end
          if (c[3:2] == cbm_pkg::CO_GREY || c[3:2] == cbm_pkg::CO_BLACK)
            map_codes[i] = code_of(cbm_pkg::CO_WHITE, c[1:0]);
        end
      end
      cbm_pkg::FN_REWIND: roving = 0;
      default: ;
    endcase
    r.used = cbm_pkg::CNT_W'(used_n);
    r.free = cbm_pkg::CNT_W'(free_n);
    r.freed = cbm_pkg::CNT_W'(freed_n);
  endtask

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 17);
  endfunction

  task automatic send_request(stim_row_t row);
    alloc_result_t r;
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= row.func;
    in_alloc_bytes <= row.bytes;
    in_cell_index <= row.idx;
    in_conservative <= row.cons;
    do @(posedge clk); while (!in_ready);
    predict_alloc(row.func, row.bytes, row.idx, row.cons, r);
    if (row.typed) begin
      r.status = row.status;
      r.fcell = row.fcell;
      r.ctype = row.ctype;
    end
    pending_results.push_back(r);
  endtask

  task automatic write_reg(logic [cbm_pkg::CFG_IDX_W-1:0] idx,
                           logic [cbm_pkg::HDR_W-1:0] val);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == cbm_pkg::CFG_HEADER) begin
      hdr_cells = 32'(val);
      preset_chunk();
    end else if (idx == cbm_pkg::CFG_PINNED) begin
      chunk_pinned = val[0];
    end
  endtask

  function automatic stim_row_t rand_row();
    stim_row_t s;
    int pick;
    s = '{default: '0};
    pick = $urandom_range(0, 99);
    s.cons = 1'($urandom_range(0, 1));
    s.idx = cbm_pkg::CELL_W'($urandom);
    s.bytes = cbm_pkg::BYTES_W'($urandom);
    if (pick < 25) s.func = cbm_pkg::FN_PAIR;
    else if (pick < 50) begin
      s.func = cbm_pkg::FN_OBJ;
      case ($urandom_range(0, 9))
        0: s.bytes = cbm_pkg::BYTES_W'($urandom_range(1024, cbm_pkg::MAX_BYTES));
        1: ;
        default: s.bytes = cbm_pkg::BYTES_W'($urandom_range(0, 200));
      endcase
    end else if (pick < 80) begin
      s.func = cbm_pkg::FN_MARK;
      // mostly aim at cells that have been handed out
      if ($urandom_range(0, 4) != 0) s.idx = cbm_pkg::CELL_W'($urandom_range(0, roving + 8));
    end else if (pick < 88) s.func = cbm_pkg::FN_SWEEP;
    else if (pick < 95) s.func = cbm_pkg::FN_REWIND;
    else s.func = cbm_pkg::FUNC_W'($urandom_range(FN_UNK_LO, FN_UNK_HI));
    return s;
  endfunction

  // result side
  initial begin
    int stall;
    alloc_result_t want;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        report("unexpected result item", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) report("status", out_status, want.status);
        if (out_found_cell !== want.fcell) report("found_cell", out_found_cell, want.fcell);
        if (out_found_type !== want.ctype) report("found_type", out_found_type, want.ctype);
        if (out_used_cells !== want.used) report("used_cells", out_used_cells, want.used);
        if (out_free_cells !== want.free) report("free_cells", out_free_cells, want.free);
        if (out_freed_cells !== want.freed) report("freed_cells", out_freed_cells, want.freed);
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    errors = 0;
    no_idle = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_func <= cbm_pkg::FN_PAIR;
    in_alloc_bytes <= '0;
    in_cell_index <= '0;
    in_conservative <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= cbm_pkg::CFG_HEADER;
    cfg_wdata <= '0;
    hdr_cells = 4;
    chunk_pinned = 0;
    preset_chunk();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    //   func                bytes  idx   cons typed status              cell type
    rows = '{
      '{cbm_pkg::FN_PAIR,   0,     0,    0, 1, cbm_pkg::ST_DONE,   4, cbm_pkg::TY_PAIR},
      '{cbm_pkg::FN_OBJ,    0,     0,    0, 1, cbm_pkg::ST_DONE,   5, cbm_pkg::TY_HEAD},
      '{cbm_pkg::FN_OBJ,    16384, 0,    0, 1, cbm_pkg::ST_DONE,   6, cbm_pkg::TY_HEAD},
      '{cbm_pkg::FN_OBJ,    16385, 0,    0, 1, cbm_pkg::ST_FULL,   0, cbm_pkg::TY_FREE},
      '{cbm_pkg::FN_OBJ,    32767, 4095, 1, 1, cbm_pkg::ST_FULL,   0, cbm_pkg::TY_FREE},
      '{cbm_pkg::FN_MARK,   0,     4,    0, 1, cbm_pkg::ST_DONE,   4, cbm_pkg::TY_PAIR},
      '{cbm_pkg::FN_MARK,   0,     4,    0, 1, cbm_pkg::ST_MARKED, 4, cbm_pkg::TY_PAIR},
      '{cbm_pkg::FN_MARK,   0,     7,    0, 1, cbm_pkg::ST_NOTOBJ, 0, cbm_pkg::TY_FREE},
      '{cbm_pkg::FN_MARK,   0,     7,    1, 1, cbm_pkg::ST_DONE,   6, cbm_pkg::TY_HEAD},
      '{cbm_pkg::FN_MARK,   0,     100,  1, 1, cbm_pkg::ST_MARKED, 6, cbm_pkg::TY_HEAD},
      '{cbm_pkg::FN_MARK,   0,     6,    0, 1, cbm_pkg::ST_DONE,   6, cbm_pkg::TY_HEAD},
      '{cbm_pkg::FN_MARK,   0,     4095, 0, 1, cbm_pkg::ST_NOTOBJ, 0, cbm_pkg::TY_FREE},
      '{cbm_pkg::FN_MARK,   0,     2,    1, 1, cbm_pkg::ST_NOTOBJ, 0, cbm_pkg::TY_FREE},
      '{cbm_pkg::FN_MARK,   0,     5,    0, 1, cbm_pkg::ST_DONE,   5, cbm_pkg::TY_HEAD},
      '{cbm_pkg::FN_OBJ,    100,   0,    0, 0, cbm_pkg::ST_DONE,   0, cbm_pkg::TY_FREE},
      '{cbm_pkg::FN_SWEEP,  0,     0,    0, 0, cbm_pkg::ST_DONE,   0, cbm_pkg::TY_FREE},
      '{FN_UNK_LO,          7,     9,    1, 1, cbm_pkg::ST_DONE,   0, cbm_pkg::TY_FREE},
      '{FN_UNK_HI,          0,     0,    0, 1, cbm_pkg::ST_DONE,   0, cbm_pkg::TY_FREE},
      '{cbm_pkg::FN_REWIND, 0,     0,    0, 1, cbm_pkg::ST_DONE,   0, cbm_pkg::TY_FREE},
      '{cbm_pkg::FN_PAIR,   0,     0,    0, 0, cbm_pkg::ST_DONE,   0, cbm_pkg::TY_FREE},
      '{cbm_pkg::FN_SWEEP,  0,     0,    0, 0, cbm_pkg::ST_DONE,   0, cbm_pkg::TY_FREE}
    };
    foreach (rows[k]) send_request(rows[k]);

    // pinned chunk refuses allocations but still whitens on sweep
    write_reg(cbm_pkg::CFG_PINNED, 8'h01);
    send_request('{cbm_pkg::FN_PAIR, 0, 0, 0, 1, cbm_pkg::ST_FULL, 0, cbm_pkg::TY_FREE});
    send_request('{cbm_pkg::FN_OBJ, 8, 0, 0, 1, cbm_pkg::ST_FULL, 0, cbm_pkg::TY_FREE});
    send_request('{cbm_pkg::FN_SWEEP, 0, 0, 0, 0, cbm_pkg::ST_DONE, 0, cbm_pkg::TY_FREE});
    write_reg(CFG_NONE_LO, 8'hff);
    write_reg(CFG_NONE_HI, 8'h00);

    for (int phase = 0; phase < 6; phase++) begin
      no_idle = (phase == 2);
      case (phase)
        0: write_reg(cbm_pkg::CFG_HEADER, 8'd0);
        1: write_reg(cbm_pkg::CFG_HEADER, 8'd255);
        default: write_reg(cbm_pkg::CFG_HEADER, cbm_pkg::HDR_W'($urandom));
      endcase
      write_reg(cbm_pkg::CFG_PINNED, (phase == 4) ? 8'h01 : 8'hfe);
      repeat (20) send_request(rand_row());
    end

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cbm_pkg.sv
rtl/cbm_ram.sv
rtl/cell_bitmap_alloc_mark_sweep.sv
tb/cell_bitmap_alloc_mark_sweep_test.sv
